[rtl/aar_pkg.sv]
// ----------------------------------------------------------------------------
// aar_pkg: shared types and constants for the axis-angle rotation matrix.
// Holds the Q30 format constants, the angle reduction constants and the
// helpers for rounded fixed point products.
// ----------------------------------------------------------------------------
package aar_pkg;

	localparam int Q = 30;
	localparam logic signed [32:0] Q30_ONE = 33'sd1073741824;
	localparam logic [25:0] DEG360 = 26'd23592960;
	localparam logic [25:0] DEG90 = 26'd5898240;
	localparam logic [25:0] DEG45 = 26'd2949120;
	localparam logic [24:0] RAD_PER_DEG = 25'd18740330;

	// Signed Q30 value, wide enough for magnitudes up to 2^31.
	typedef logic signed [32:0] q30_t;

	// Rounded (half away from zero) product of two Q30 values, scaled by 2^-30.
	function automatic q30_t qmul(input q30_t a, input q30_t b);
		logic signed [65:0] p;
		logic [65:0] m;
		logic [35:0] r;
		p = a * b;
		m = p[65] ? 66'(-p) : 66'(p);
		r = 36'((m + 66'd536870912) >> 30);
		return p[65] ? -q30_t'(r) : q30_t'(r);
	endfunction

	// Rounded quotient of a nonnegative Q30 value (at most 2^30) by a small
	// constant. The caller gives half the divisor and the reciprocal m with
	// its shift s, chosen so that (t * m) >> s is exact for every t below 2^31.
	function automatic q30_t divr(input q30_t v, input logic [21:0] half,
			input logic [32:0] m, input logic [5:0] s);
		logic [30:0] t;
		logic [63:0] p;
		t = 31'(v) + 31'(half);
		p = 64'(t) * 64'(m);
		return q30_t'(p >> s);
	endfunction

endpackage

[rtl/aar_sincos.sv]
// ----------------------------------------------------------------------------
// aar_sincos: pipelined sine and cosine of a Q16.16 degree angle.
// Reduces the angle, forms the Q30 radian value, then builds the powers of
// the argument one product per stage and sums the Taylor series.
// ----------------------------------------------------------------------------
module aar_sincos (
	input  logic                 clk,
	input  logic                 en,
	input  logic signed [25:0]   angle,
	output aar_pkg::q30_t        sin_o,
	output aar_pkg::q30_t        cos_o
);

	localparam int NP = 10;

	// Reciprocals for the series divisors: ceil(2^s / D) with s = 31 + ceil(log2 D).
	localparam logic [32:0] RC6 = 33'(((64'd1 << 34) + 64'd5) / 64'd6);
	localparam logic [32:0] RC24 = 33'(((64'd1 << 36) + 64'd23) / 64'd24);
	localparam logic [32:0] RC120 = 33'(((64'd1 << 38) + 64'd119) / 64'd120);
	localparam logic [32:0] RC720 = 33'(((64'd1 << 41) + 64'd719) / 64'd720);
	localparam logic [32:0] RC5040 = 33'(((64'd1 << 44) + 64'd5039) / 64'd5040);
	localparam logic [32:0] RC40320 = 33'(((64'd1 << 47) + 64'd40319) / 64'd40320);
	localparam logic [32:0] RC362880 = 33'(((64'd1 << 50) + 64'd362879) / 64'd362880);
	localparam logic [32:0] RC3628800 = 33'(((64'd1 << 53) + 64'd3628799) / 64'd3628800);

	localparam logic signed [27:0] D360 = 28'(aar_pkg::DEG360);

	// Stages 1 and 2: reduction to [0,360), then quadrant split. The input stays
	// within two turns either way, so at most two corrections are needed.
	logic [25:0] r_s1;
	logic signed [27:0] a_ext;
	logic signed [27:0] red;
	always_comb begin
		a_ext = 28'(angle);
		if (a_ext < 0) begin
			red = a_ext + D360;
			if (red < 0) red = red + D360;
		end else if (a_ext >= D360) red = a_ext - D360;
		else red = a_ext;
	end
	always_ff @(posedge clk) if (en) r_s1 <= 26'(red);

	logic [1:0] quad_s2;
	logic [25:0] d_s2;
	logic swap_s2;
	logic [1:0] qd;
	logic [25:0] dd;
	always_comb begin
		if (r_s1 >= 26'(3 * 5898240)) qd = 2'd3;
		else if (r_s1 >= 26'(2 * 5898240)) qd = 2'd2;
		else if (r_s1 >= aar_pkg::DEG90) qd = 2'd1;
		else qd = 2'd0;
		dd = r_s1 - 26'(32'(qd) * 32'(aar_pkg::DEG90));
	end
	always_ff @(posedge clk) if (en) begin
		quad_s2 <= qd;
		swap_s2 <= dd > aar_pkg::DEG45;
		d_s2 <= (dd > aar_pkg::DEG45) ? aar_pkg::DEG90 - dd : dd;
	end

	// Stage 3: radian value in Q30.
	aar_pkg::q30_t x_s3;
	logic [1:0] quad_s3;
	logic swap_s3;
	logic [48:0] xp;
	assign xp = 49'(d_s2) * 49'(aar_pkg::RAD_PER_DEG) + 49'd32768;
	always_ff @(posedge clk) if (en) begin
		x_s3 <= aar_pkg::q30_t'(xp >> 16);
		quad_s3 <= quad_s2;
		swap_s3 <= swap_s2;
	end

	// Power chain: one product per stage, earlier powers ride along.
	aar_pkg::q30_t pw [NP+1][NP+1];
	logic [1:0] quad_p [NP+1];
	logic swap_p [NP+1];
	always_comb begin
		for (int i = 0; i <= NP; i++) pw[1][i] = (i == 1) ? x_s3 : '0;
		quad_p[1] = quad_s3;
		swap_p[1] = swap_s3;
	end
	for (genvar k = 2; k <= NP; k++) begin : g_pow
		always_ff @(posedge clk) if (en) begin
			for (int i = 0; i <= NP; i++)
				pw[k][i] <= (i == k) ? aar_pkg::qmul(pw[k-1][k-1], pw[k-1][1])
				                     : pw[k-1][i];
			quad_p[k] <= quad_p[k-1];
			swap_p[k] <= swap_p[k-1];
		end
	end

	// Series terms, registered.
	aar_pkg::q30_t t_s [NP+1];
	logic [1:0] quad_t;
	logic swap_t;
	always_ff @(posedge clk) if (en) begin
		t_s[0] <= '0;
		t_s[1] <= pw[NP][1];
		t_s[2] <= aar_pkg::q30_t'((34'(pw[NP][2]) + 34'd1) >> 1);
		t_s[3] <= aar_pkg::divr(pw[NP][3], 22'd3, RC6, 6'd34);
		t_s[4] <= aar_pkg::divr(pw[NP][4], 22'd12, RC24, 6'd36);
		t_s[5] <= aar_pkg::divr(pw[NP][5], 22'd60, RC120, 6'd38);
		t_s[6] <= aar_pkg::divr(pw[NP][6], 22'd360, RC720, 6'd41);
		t_s[7] <= aar_pkg::divr(pw[NP][7], 22'd2520, RC5040, 6'd44);
		t_s[8] <= aar_pkg::divr(pw[NP][8], 22'd20160, RC40320, 6'd47);
		t_s[9] <= aar_pkg::divr(pw[NP][9], 22'd181440, RC362880, 6'd50);
		t_s[10] <= aar_pkg::divr(pw[NP][10], 22'd1814400, RC3628800, 6'd53);
		quad_t <= quad_p[NP];
		swap_t <= swap_p[NP];
	end

	aar_pkg::q30_t s_sum, c_sum, s_c, c_c, s_w, c_w;
	always_comb begin
		s_sum = t_s[1] - t_s[3] + t_s[5] - t_s[7] + t_s[9];
		c_sum = aar_pkg::Q30_ONE - t_s[2] + t_s[4] - t_s[6] + t_s[8] - t_s[10] + t_s[0];
		s_c = (s_sum < 0) ? '0 : ((s_sum > aar_pkg::Q30_ONE) ? aar_pkg::Q30_ONE : s_sum);
		c_c = (c_sum < 0) ? '0 : ((c_sum > aar_pkg::Q30_ONE) ? aar_pkg::Q30_ONE : c_sum);
		s_w = swap_t ? c_c : s_c;
		c_w = swap_t ? s_c : c_c;
	end
	always_ff @(posedge clk) if (en) begin
		case (quad_t)
			2'd0: begin sin_o <= s_w; cos_o <= c_w; end
			2'd1: begin sin_o <= c_w; cos_o <= -s_w; end
			2'd2: begin sin_o <= -s_w; cos_o <= -c_w; end
			default: begin sin_o <= -c_w; cos_o <= s_w; end
		endcase
	end

endmodule

[rtl/aar_axisnorm.sv]
// ----------------------------------------------------------------------------
// aar_axisnorm: pipelined unit vector of the axis.
// Scales the magnitudes up, takes an integer square root one bit per stage
// and divides each component by the length with a restoring divider, one
// quotient bit per stage.
// ----------------------------------------------------------------------------
module aar_axisnorm #(
	parameter int AXIS_BITS = 16
) (
	input  logic                        clk,
	input  logic                        en,
	input  logic signed [AXIS_BITS-1:0] ax,
	input  logic signed [AXIS_BITS-1:0] ay,
	input  logic signed [AXIS_BITS-1:0] az,
	output aar_pkg::q30_t               w0,
	output aar_pkg::q30_t               w1,
	output aar_pkg::q30_t               w2,
	output logic                        zero
);

	localparam int MW = 33;        // normalized magnitude below 2^31
	localparam int SB = 33;        // sqrt result bits
	localparam int DB = 32;        // quotient bits

	// Stage 1: magnitudes, signs and the largest magnitude.
	logic [AXIS_BITS:0] m_c [3];
	logic [AXIS_BITS:0] mx;
	always_comb begin
		m_c[0] = ax[AXIS_BITS-1] ? (AXIS_BITS+1)'(-$signed({ax[AXIS_BITS-1], ax}))
		                         : (AXIS_BITS+1)'(ax);
		m_c[1] = ay[AXIS_BITS-1] ? (AXIS_BITS+1)'(-$signed({ay[AXIS_BITS-1], ay}))
		                         : (AXIS_BITS+1)'(ay);
		m_c[2] = az[AXIS_BITS-1] ? (AXIS_BITS+1)'(-$signed({az[AXIS_BITS-1], az}))
		                         : (AXIS_BITS+1)'(az);
		mx = m_c[0];
		if (m_c[1] > mx) mx = m_c[1];
		if (m_c[2] > mx) mx = m_c[2];
	end
	logic [AXIS_BITS:0] m_s1 [3];
	logic [AXIS_BITS:0] mx_s1;
	logic [2:0] neg_s1;
	always_ff @(posedge clk) if (en) begin
		m_s1 <= m_c;
		mx_s1 <= mx;
		neg_s1 <= {az[AXIS_BITS-1], ay[AXIS_BITS-1], ax[AXIS_BITS-1]};
	end

	// Stage 2: shift count by priority encode, then shift, and the zero flag.
	logic [5:0] k;
	logic [63:0] mxw;
	always_comb begin
		k = '0;
		mxw = 64'(mx_s1);
		for (int b = 0; b < 64; b++)
			if (mxw[b] && b <= 30) k = 6'(30 - b);
	end
	logic [MW-1:0] n_s2 [3];
	logic [2:0] neg_s2;
	logic zero_s2;
	always_ff @(posedge clk) if (en) begin
		for (int i = 0; i < 3; i++) n_s2[i] <= MW'(64'(m_s1[i]) << k);
		neg_s2 <= neg_s1;
		zero_s2 <= (mx_s1 == '0);
	end

	// Stage 3: sum of squares (three multipliers, one adder tree).
	logic [67:0] l2_s3;
	logic [MW-1:0] n_s3 [3];
	logic [2:0] neg_s3;
	logic zero_s3;
	always_ff @(posedge clk) if (en) begin
		l2_s3 <= 68'(n_s2[0]) * 68'(n_s2[0]) + 68'(n_s2[1]) * 68'(n_s2[1])
		       + 68'(n_s2[2]) * 68'(n_s2[2]);
		n_s3 <= n_s2;
		neg_s3 <= neg_s2;
		zero_s3 <= zero_s2;
	end

	// Square root, one result bit per stage.
	logic [67:0] sr_rem [SB+1];
	logic [SB-1:0] sr_root [SB+1];
	logic [MW-1:0] sr_n [SB+1][3];
	logic [2:0] sr_neg [SB+1];
	logic sr_zero [SB+1];
	always_comb begin
		sr_rem[0] = l2_s3;
		sr_root[0] = '0;
		sr_n[0] = n_s3;
		sr_neg[0] = neg_s3;
		sr_zero[0] = zero_s3;
	end
	for (genvar b = 0; b < SB; b++) begin : g_sqrt
		localparam int BIT = SB - 1 - b;
		logic [SB-1:0] trial;
		logic [67:0] sq;
		assign trial = sr_root[b] | (SB'(1) << BIT);
		assign sq = 68'(trial) * 68'(trial);
		always_ff @(posedge clk) if (en) begin
			sr_root[b+1] <= (sq <= sr_rem[b]) ? trial : sr_root[b];
			sr_rem[b+1] <= sr_rem[b];
			sr_n[b+1] <= sr_n[b];
			sr_neg[b+1] <= sr_neg[b];
			sr_zero[b+1] <= sr_zero[b];
		end
	end

	// Division (n << 30 + L/2) / L, one quotient bit per stage for all three.
	// The dividend above its low DB bits is already below L, so the partial
	// remainder starts there and the low bits are brought down one a stage.
	localparam int NW = MW + 31;
	logic [NW-1:0] num0 [3];
	logic [SB:0] dv_rem [DB+1][3];
	logic [DB-1:0] dv_lo [DB+1][3];
	logic [DB-1:0] dv_q [DB+1][3];
	logic [SB-1:0] dv_l [DB+1];
	logic [2:0] dv_neg [DB+1];
	logic dv_zero [DB+1];
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			num0[i] = (NW'(sr_n[SB][i]) << 30) + NW'(sr_root[SB] >> 1);
			dv_rem[0][i] = (SB+1)'(num0[i] >> DB);
			dv_lo[0][i] = num0[i][DB-1:0];
			dv_q[0][i] = '0;
		end
		dv_l[0] = (sr_root[SB] == '0) ? SB'(1) : sr_root[SB];
		dv_neg[0] = sr_neg[SB];
		dv_zero[0] = sr_zero[SB];
	end
	for (genvar b = 0; b < DB; b++) begin : g_div
		for (genvar i = 0; i < 3; i++) begin : g_c
			logic [SB:0] tr;
			assign tr = {dv_rem[b][i][SB-1:0], dv_lo[b][i][DB-1]};
			always_ff @(posedge clk) if (en) begin
				if (tr >= (SB+1)'(dv_l[b])) begin
					dv_rem[b+1][i] <= tr - (SB+1)'(dv_l[b]);
					dv_q[b+1][i] <= {dv_q[b][i][DB-2:0], 1'b1};
				end else begin
					dv_rem[b+1][i] <= tr;
					dv_q[b+1][i] <= {dv_q[b][i][DB-2:0], 1'b0};
				end
				dv_lo[b+1][i] <= {dv_lo[b][i][DB-2:0], 1'b0};
			end
		end
		always_ff @(posedge clk) if (en) begin
			dv_l[b+1] <= dv_l[b];
			dv_neg[b+1] <= dv_neg[b];
			dv_zero[b+1] <= dv_zero[b];
		end
	end

	always_ff @(posedge clk) if (en) begin
		w0 <= dv_neg[DB][0] ? -aar_pkg::q30_t'(dv_q[DB][0]) : aar_pkg::q30_t'(dv_q[DB][0]);
		w1 <= dv_neg[DB][1] ? -aar_pkg::q30_t'(dv_q[DB][1]) : aar_pkg::q30_t'(dv_q[DB][1]);
		w2 <= dv_neg[DB][2] ? -aar_pkg::q30_t'(dv_q[DB][2]) : aar_pkg::q30_t'(dv_q[DB][2]);
		zero <= dv_zero[DB];
	end

endmodule

[rtl/aar_matrix.sv]
// ----------------------------------------------------------------------------
// aar_matrix: Rodrigues entries from unit axis, sine and cosine.
// Three register stages: products; second products with their sum; output rounding.
// ----------------------------------------------------------------------------
module aar_matrix #(
	parameter int OUT_FRAC_BITS = 16
) (
	input  logic                 clk,
	input  logic                 en,
	input  aar_pkg::q30_t        w [3],
	input  aar_pkg::q30_t        s,
	input  aar_pkg::q30_t        c,
	input  logic                 zero,
	output logic signed [OUT_FRAC_BITS+1:0] r [9]
);

	localparam int SH = 30 - OUT_FRAC_BITS;

	aar_pkg::q30_t ww_s1 [9];
	aar_pkg::q30_t sw_s1 [3];
	aar_pkg::q30_t c_s1, omc_s1;
	logic zero_s1;
	always_ff @(posedge clk) if (en) begin
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) ww_s1[i*3+j] <= aar_pkg::qmul(w[i], w[j]);
			sw_s1[i] <= aar_pkg::qmul(s, w[i]);
		end
		c_s1 <= c;
		omc_s1 <= aar_pkg::Q30_ONE - c;
		zero_s1 <= zero;
	end

	aar_pkg::q30_t sum_s2 [9];
	logic zero_s2;
	always_ff @(posedge clk) if (en) begin
		for (int i = 0; i < 3; i++)
			for (int j = 0; j < 3; j++) begin
				sum_s2[i*3+j] <= aar_pkg::qmul(ww_s1[i*3+j], omc_s1)
					+ ((i == j) ? c_s1 : '0)
					+ ((i == 0 && j == 1) ? -sw_s1[2] : '0)
					+ ((i == 0 && j == 2) ? sw_s1[1] : '0)
					+ ((i == 1 && j == 0) ? sw_s1[2] : '0)
					+ ((i == 1 && j == 2) ? -sw_s1[0] : '0)
					+ ((i == 2 && j == 0) ? -sw_s1[1] : '0)
					+ ((i == 2 && j == 1) ? sw_s1[0] : '0);
			end
		zero_s2 <= zero_s1;
	end

	logic [33:0] mag [9];
	logic [33:0] rm [9];
	always_comb begin
		for (int e = 0; e < 9; e++) begin
			mag[e] = sum_s2[e][32] ? 34'(-sum_s2[e]) : 34'(sum_s2[e]);
			if (SH > 0) rm[e] = (mag[e] + (34'(1) << (SH > 0 ? SH - 1 : 0))) >> SH;
			else rm[e] = mag[e];
			if (rm[e] > (34'(1) << OUT_FRAC_BITS)) rm[e] = 34'(1) << OUT_FRAC_BITS;
		end
	end
	always_ff @(posedge clk) if (en) begin
		for (int e = 0; e < 9; e++) begin
			if (zero_s2)
				r[e] <= (e == 0 || e == 4 || e == 8)
				        ? (OUT_FRAC_BITS+2)'(34'(1) << OUT_FRAC_BITS) : '0;
			else
				r[e] <= sum_s2[e][32] ? -(OUT_FRAC_BITS+2)'(rm[e])
				                      : (OUT_FRAC_BITS+2)'(rm[e]);
		end
	end

endmodule

[rtl/axis_angle_rotation_matrix.sv]
// ----------------------------------------------------------------------------
// axis_angle_rotation_matrix: 3x3 rotation matrix from angle and axis.
// Rodrigues form R = c*I + s*K + (1-c)*w*w^T in Q30, rounded to Q1.F.
//
//   channel  | handshake       | words
//   input    | start / busy    | angle_deg, axis_x, axis_y, axis_z
//   result   | done strobe     | r_rowI_colJ (nine), axis_zero
//
// One word enters per cycle; busy is tied low since nothing stalls.
// The time from the accepting edge to done is set by the axis path: 3 front
// stages, a square root with one bit per stage (33), a divider with one
// quotient bit per stage (32), an output register, and then 3 matrix stages.
// The angle path (14 stages) is delayed to line up.
// Reset clears only the valid bits that travel with each word.
// ----------------------------------------------------------------------------
module axis_angle_rotation_matrix #(
	parameter int OUT_FRAC_BITS = 16,
	parameter int AXIS_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic signed [25:0]            angle_deg,
	input  logic signed [AXIS_BITS-1:0]   axis_x,
	input  logic signed [AXIS_BITS-1:0]   axis_y,
	input  logic signed [AXIS_BITS-1:0]   axis_z,
	output logic                          done,
	output logic signed [OUT_FRAC_BITS+1:0] r_row0_col0,
	output logic signed [OUT_FRAC_BITS+1:0] r_row0_col1,
	output logic signed [OUT_FRAC_BITS+1:0] r_row0_col2,
	output logic signed [OUT_FRAC_BITS+1:0] r_row1_col0,
	output logic signed [OUT_FRAC_BITS+1:0] r_row1_col1,
	output logic signed [OUT_FRAC_BITS+1:0] r_row1_col2,
	output logic signed [OUT_FRAC_BITS+1:0] r_row2_col0,
	output logic signed [OUT_FRAC_BITS+1:0] r_row2_col1,
	output logic signed [OUT_FRAC_BITS+1:0] r_row2_col2,
	output logic                          axis_zero
);

	// Axis path depth: 3 front stages, 33 root bits, 32 quotient bits, output.
	localparam int AX_LAT = 3 + 33 + 32 + 1;
	// Angle path depth: 3 front stages, 9 power stages, terms, output.
	localparam int AN_LAT = 3 + 9 + 1 + 1;
	localparam int DLY = AX_LAT - AN_LAT;
	localparam int TOT = AX_LAT + 3;

	// The pipeline never holds off, so every stage advances each cycle.
	logic en;
	assign en = 1'b1;
	assign busy = 1'b0;

	aar_pkg::q30_t s_a, c_a;
	aar_sincos u_sc (
		.clk(clk), .en(en), .angle(angle_deg),
		.sin_o(s_a), .cos_o(c_a)
	);

	aar_pkg::q30_t w [3];
	logic zero_w;
	aar_axisnorm #(.AXIS_BITS(AXIS_BITS)) u_an (
		.clk(clk), .en(en), .ax(axis_x), .ay(axis_y), .az(axis_z),
		.w0(w[0]), .w1(w[1]), .w2(w[2]), .zero(zero_w)
	);

	// Delay line that brings sine and cosine level with the unit axis.
	aar_pkg::q30_t sd [DLY+1];
	aar_pkg::q30_t cd [DLY+1];
	assign sd[0] = s_a;
	assign cd[0] = c_a;
	for (genvar i = 0; i < DLY; i++) begin : g_dly
		always_ff @(posedge clk) begin
			sd[i+1] <= sd[i];
			cd[i+1] <= cd[i];
		end
	end

	logic signed [OUT_FRAC_BITS+1:0] r [9];
	aar_matrix #(.OUT_FRAC_BITS(OUT_FRAC_BITS)) u_mx (
		.clk(clk), .en(en), .w(w), .s(sd[DLY]), .c(cd[DLY]), .zero(zero_w), .r(r)
	);

	// Zero flag follows the matrix stages.
	logic [2:0] zq_q;
	always_ff @(posedge clk) zq_q <= {zq_q[1:0], zero_w};

	// Valid bits travel alongside the words.
	logic [TOT-1:0] vld_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_q <= '0;
		else vld_q <= {vld_q[TOT-2:0], start};
	end

	assign done = vld_q[TOT-1];
	assign axis_zero = zq_q[2];
	assign r_row0_col0 = r[0];
	assign r_row0_col1 = r[1];
	assign r_row0_col2 = r[2];
	assign r_row1_col0 = r[3];
	assign r_row1_col1 = r[4];
	assign r_row1_col2 = r[5];
	assign r_row2_col0 = r[6];
	assign r_row2_col1 = r[7];
	assign r_row2_col2 = r[8];

endmodule

[rtl/aar_checker.sv]
// ----------------------------------------------------------------------------
// aar_checker: port-level checks for the rotation matrix block.
// Watches the handshake, the identity output for a zero axis and the range of r_row0_col0.
// ----------------------------------------------------------------------------
module aar_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               busy,
	input logic               done,
	input logic               axis_zero,
	input logic signed [17:0] r_row0_col0,
	input logic signed [17:0] r_row0_col1,
	input logic signed [17:0] r_row1_col1
);

	a_busy: assert property (@(posedge clk) disable iff (!arst_n) !busy)
		else $error("busy raised");
	a_zero_id: assert property (@(posedge clk) disable iff (!arst_n)
		done && axis_zero |-> r_row0_col0 == 18'sd65536 && r_row0_col1 == 18'sd0
		&& r_row1_col1 == 18'sd65536)
		else $error("zero axis without identity");
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> r_row0_col0 <= 18'sd65536 && r_row0_col0 >= -18'sd65536)
		else $error("entry out of range");

endmodule

bind axis_angle_rotation_matrix aar_checker u_chk (
	.clk(clk), .arst_n(arst_n), .busy(busy), .done(done), .axis_zero(axis_zero),
	.r_row0_col0(r_row0_col0[17:0]), .r_row0_col1(r_row0_col1[17:0]),
	.r_row1_col1(r_row1_col1[17:0])
);

[verif/tb_axis_angle_rotation_matrix.sv]
// ----------------------------------------------------------------------------
// tb_axis_angle_rotation_matrix: self-checking bench for the rotation block.
// A directed table and then random angle/axis words are sent in bursts.
// Every accepted word is run through a bit-exact fixed point model of the
// Rodrigues matrix, and each result strobe is checked against the oldest
// expected matrix.
// ----------------------------------------------------------------------------
module tb_axis_angle_rotation_matrix;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int FRAC = 16;
	localparam longint ONE_Q30 = 64'sd1 << 30;
	localparam logic signed [17:0] OUT_ONE = 18'sd65536;

	// One expected matrix and its zero-axis flag.
	typedef struct {
		logic signed [17:0] ent[9];
		logic               zero;
	} matrix_t;

	// A row of the directed table. Where typed is set, the expected result is
	// the identity matrix with the given flag, which holds for a zero axis and
	// for a zero angle about any axis.
	typedef struct {
		int          ang;
		shortint     ax, ay, az;
		bit          typed;
		bit          typed_zero;
	} vec_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic signed [25:0] angle_deg = '0;
	logic signed [15:0] axis_x = '0, axis_y = '0, axis_z = '0;
	wire busy, done, axis_zero;
	wire signed [17:0] r00, r01, r02, r10, r11, r12, r20, r21, r22;

	matrix_t pending_mats[$];
	int mismatches = 0;

	always #5 clk = ~clk;

	axis_angle_rotation_matrix i_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.angle_deg(angle_deg), .axis_x(axis_x), .axis_y(axis_y), .axis_z(axis_z),
		.done(done),
		.r_row0_col0(r00), .r_row0_col1(r01), .r_row0_col2(r02),
		.r_row1_col0(r10), .r_row1_col1(r11), .r_row1_col2(r12),
		.r_row2_col0(r20), .r_row2_col1(r21), .r_row2_col2(r22),
		.axis_zero(axis_zero)
	);

	// Product of two Q30 values, rounded half away from zero.
	function automatic longint mul_q30(longint a, longint b);
		longint p, m;
		p = a * b;
		m = (p < 0) ? -p : p;
		m = (m + (64'sd1 << 29)) >>> 30;
		return (p < 0) ? -m : m;
	endfunction

	function automatic longint div_round(longint v, longint d);
		return (v + d / 2) / d;
	endfunction

	function automatic longint clamp_unit(longint v);
		return (v < 0) ? 0 : ((v > ONE_Q30) ? ONE_Q30 : v);
	endfunction

	function automatic bit [63:0] int_sqrt(bit [63:0] v);
		bit [63:0] res, b;
		res = 0;
		b = 64'd1 << 62;
		while (b > v)
			b >>= 2;
		while (b != 0) begin
			if (v >= res + b) begin
				v -= res + b;
				res = (res >> 1) + b;
			end else begin
				res >>= 1;
			end
			b >>= 2;
		end
		return res;
	endfunction

	// Sine and cosine of a Q16.16 degree angle, in Q30, from a Taylor series
	// on the first octant with the quadrant applied afterwards.
	task automatic sin_cos_deg(input longint ang, output longint sn, output longint cs);
		longint r, quad, d, x, s, c, t;
		longint pw[11];
		bit swap;
		r = ang % longint'(aar_pkg::DEG360);
		if (r < 0)
			r += longint'(aar_pkg::DEG360);
		quad = r / longint'(aar_pkg::DEG90);
		d = r - quad * longint'(aar_pkg::DEG90);
		swap = 0;
		if (d > longint'(aar_pkg::DEG45)) begin
			d = longint'(aar_pkg::DEG90) - d;
			swap = 1;
		end
		x = (d * longint'(aar_pkg::RAD_PER_DEG) + 32768) >>> 16;
		pw[1] = x;
		for (int i = 2; i <= 10; i++)
			pw[i] = mul_q30(pw[i-1], x);
		s = x - div_round(pw[3], 6) + div_round(pw[5], 120) - div_round(pw[7], 5040)
			+ div_round(pw[9], 362880);
		c = ONE_Q30 - div_round(pw[2], 2) + div_round(pw[4], 24) - div_round(pw[6], 720)
			+ div_round(pw[8], 40320) - div_round(pw[10], 3628800);
		s = clamp_unit(s);
		c = clamp_unit(c);
		if (swap) begin
			t = s;
			s = c;
			c = t;
		end
		case (quad)
			0: begin sn = s; cs = c; end
			1: begin sn = c; cs = -s; end
			2: begin sn = -s; cs = -c; end
			default: begin sn = -c; cs = s; end
		endcase
	endtask

	// Q30 entry to Q1.16 with rounding and saturation at plus or minus one.
	function automatic logic signed [17:0] to_q1_16(longint v);
		longint m;
		m = (v < 0) ? -v : v;
		m = (m + (64'sd1 << (29 - FRAC))) >>> (30 - FRAC);
		if (m > (64'sd1 << FRAC))
			m = 64'sd1 << FRAC;
		return (v < 0) ? 18'(-m) : 18'(m);
	endfunction

	function automatic matrix_t identity_matrix(bit zero);
		matrix_t mt;
		for (int i = 0; i < 9; i++)
			mt.ent[i] = (i % 4 == 0) ? OUT_ONE : '0;
		mt.zero = zero;
		return mt;
	endfunction

	// The rotation matrix this block must give for one word.
	task automatic rodrigues_matrix(input longint ang, input longint a[3], output matrix_t mt);
		longint mag[3], w[3], sk[9], s, c, omc, e;
		bit [63:0] sq, len;
		longint mx;
		int k;
		mx = 0;
		for (int i = 0; i < 3; i++) begin
			mag[i] = (a[i] < 0) ? -a[i] : a[i];
			if (mag[i] > mx)
				mx = mag[i];
		end
		if (mx == 0) begin
			mt = identity_matrix(1'b1);
			return;
		end
		k = 0;
		while ((mx << k) < ONE_Q30)
			k++;
		sq = 0;
		for (int i = 0; i < 3; i++) begin
			mag[i] = mag[i] << k;
			sq += 64'(mag[i]) * 64'(mag[i]);
		end
		len = int_sqrt(sq);
		for (int i = 0; i < 3; i++) begin
			w[i] = longint'(((64'(mag[i]) << 30) + len / 2) / len);
			if (a[i] < 0)
				w[i] = -w[i];
		end
		sin_cos_deg(ang, s, c);
		omc = ONE_Q30 - c;
		sk[0] = 0;                  sk[1] = -mul_q30(s, w[2]);  sk[2] = mul_q30(s, w[1]);
		sk[3] = mul_q30(s, w[2]);   sk[4] = 0;                  sk[5] = -mul_q30(s, w[0]);
		sk[6] = -mul_q30(s, w[1]);  sk[7] = mul_q30(s, w[0]);   sk[8] = 0;
		for (int i = 0; i < 3; i++)
			for (int j = 0; j < 3; j++) begin
				e = ((i == j) ? c : 0) + mul_q30(mul_q30(w[i], w[j]), omc) + sk[i*3+j];
				mt.ent[i*3+j] = to_q1_16(e);
			end
		mt.zero = 1'b0;
	endtask

	// Drives one word from the falling edge and holds it until it is taken.
	// The expected matrix is queued at the edge that accepts the word.
	task automatic send_word(input int ang, input shortint ax, input shortint ay,
			input shortint az, input bit typed, input bit typed_zero);
		matrix_t mt;
		longint a[3];
		@(negedge clk);
		start <= 1'b1;
		angle_deg <= 26'(ang);
		axis_x <= ax;
		axis_y <= ay;
		axis_z <= az;
		do
			@(posedge clk);
		while (busy);
		if (typed) begin
			mt = identity_matrix(typed_zero);
		end else begin
			a[0] = ax;
			a[1] = ay;
			a[2] = az;
			rodrigues_matrix(ang, a, mt);
		end
		pending_mats.push_back(mt);
	endtask

	task automatic idle_cycles(input int n);
		repeat (n) begin
			@(negedge clk);
			start <= 1'b0;
		end
	endtask

	function automatic shortint rand_axis_part();
		case ($urandom_range(0, 5))
			0: return 16'sd0;
			1: return shortint'($urandom_range(0, 8)) - 16'sd4;
			2: return ($urandom_range(0, 1)) ? 16'sh7fff : 16'sh8000;
			default: return shortint'($urandom_range(0, 65535));
		endcase
	endfunction

	function automatic int rand_angle();
		case ($urandom_range(0, 7))
			0: return ($urandom_range(0, 1)) ? 23592960 : -23592960;
			1: return int'($urandom_range(0, 16)) * 1474560 - 11796480;
			2: return int'($urandom_range(0, 8)) * 2949120 - 11796480
				+ int'($urandom_range(0, 4)) - 2;
			default: return int'($urandom_range(0, 47185920)) - 23592960;
		endcase
	endfunction

	// Results cannot be held off, so each strobe is checked on the edge that
	// ends its cycle. Values read here are those from before the edge.
	always @(posedge clk) begin
		matrix_t want;
		logic signed [17:0] got[9];
		bit bad;
		if (arst_n && done) begin
			got = '{r00, r01, r02, r10, r11, r12, r20, r21, r22};
			if (pending_mats.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: result word with nothing expected", $realtime);
			end else begin
				want = pending_mats.pop_front();
				bad = (axis_zero !== want.zero);
				for (int i = 0; i < 9; i++)
					if (got[i] !== want.ent[i])
						bad = 1;
				if (bad) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("%0t: matrix mismatch, flag exp %0b got %0b", $realtime,
							want.zero, axis_zero);
						for (int i = 0; i < 9; i++)
							$display("  r%0d%0d exp %0d got %0d", i / 3, i % 3,
								want.ent[i], got[i]);
					end
				end
			end
		end
	end

	// Directed words: identities first, then the angle extremes, the octant
	// and quadrant boundaries, and axes along each coordinate and against y and z.
	vec_row_t directed[] = '{
		'{0,          0,       0,       0,       1, 1},
		'{23592960,   0,       0,       0,       1, 1},
		'{-23592960,  0,       0,       0,       1, 1},
		'{0,          1,       2,       3,       1, 0},
		'{0,          -32768,  32767,   -1,      1, 0},
		'{5898240,    0,       0,       1,       0, 0},
		'{5898240,    0,       0,       -5,      0, 0},
		'{5898240,    32767,   0,       0,       0, 0},
		'{5898240,    0,       -32768,  0,       0, 0},
		'{11796480,   1,       1,       1,       0, 0},
		'{17694720,   -1,      1,       0,       0, 0},
		'{23592960,   7,       -3,      9,       0, 0},
		'{-23592960,  32767,   32767,   32767,   0, 0},
		'{2949120,    -32768,  -32768,  -32768,  0, 0},
		'{2949121,    0,       1,       0,       0, 0},
		'{2949119,    0,       0,       32767,   0, 0},
		'{-5898240,   100,     0,       0,       0, 0},
		'{23592959,   0,       0,       1,       0, 0},
		'{-23592959,  3,       4,       0,       0, 0},
		'{1,          1,       0,       0,       0, 0},
		'{-1,         0,       0,       1,       0, 0},
		'{8847360,    -32768,  0,       1,       0, 0},
		'{14745600,   12345,   -23456,  321,     0, 0}
	};

	initial begin
		int sent, burst;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		idle_cycles(2);

		foreach (directed[i])
			send_word(directed[i].ang, directed[i].ax, directed[i].ay, directed[i].az,
				directed[i].typed, directed[i].typed_zero);

		// Random words in bursts; a gap of zero keeps start high across words.
		sent = 0;
		while (sent < 1500) begin
			burst = $urandom_range(1, 40);
			for (int b = 0; b < burst; b++)
				send_word(rand_angle(), rand_axis_part(), rand_axis_part(),
					rand_axis_part(), 0, 0);
			sent += burst;
			if ($urandom_range(0, 3) != 0)
				idle_cycles($urandom_range(1, 25));
		end
		idle_cycles(1);

		while (pending_mats.size() != 0)
			@(posedge clk);
		repeat (150) @(posedge clk);
		if (mismatches == 0)
			$display("tb_axis_angle_rotation_matrix: PASS");
		else
			$display("tb_axis_angle_rotation_matrix: FAIL");
		$finish;
	end

	initial begin
		#3ms;
		$display("tb_axis_angle_rotation_matrix: FAIL");
		$finish;
	end

endmodule
